FILE: hdl/mabr_pkg.sv
// Package for the minimum-area bounding rectangle block: widths, payload types,
// controller states and the command/status structs between controller and datapath.
// No dependencies.
`default_nettype none

package mabr_pkg;

    localparam int MAX_POINTS = 1024;
    localparam int CW         = 24;                      // coordinate width
    localparam int AW         = $clog2(MAX_POINTS + 1);  // store address width
    localparam int IW         = $clog2(MAX_POINTS + 2);  // index width, holds count + 1
    localparam int DW         = CW + 1;                  // coordinate difference
    localparam int PW         = 2 * DW;                  // product of differences
    localparam int SW         = PW + 1;                  // sum of two products
    localparam int HW         = (SW + 1) / 2;            // half operand of wide multiply
    localparam int NW         = 4 * HW;                  // wide product / numerator
    localparam int RW         = SW + 9;                  // divider remainder
    localparam int AREA_W     = 48;
    localparam int HULL_W     = 11;
    localparam int STEP_W     = $clog2(NW + 1);

    localparam logic [IW-1:0]     MAX_IDX  = IW'(MAX_POINTS);
    localparam logic [AREA_W-1:0] AREA_MAX = '1;

    typedef struct packed {
        logic signed [CW-1:0] point_x;
        logic signed [CW-1:0] point_y;
        logic                 last_point;
    } t_in_item;

    typedef struct packed {
        logic [AREA_W-1:0] min_area;
        logic [HULL_W-1:0] hull_count;
    } t_out_item;

    typedef enum logic [1:0] {
        WS_IN,
        WS_K,
        WS_C
    } t_wsel;

    typedef enum logic [5:0] {
        ST_LOAD,
        ST_FIND_RD, ST_FIND_LD, ST_FIND_WR,
        ST_SW_RD, ST_SW_LD, ST_SW_W1, ST_SW_W2,
        ST_C_RD, ST_C_LD,
        ST_SC_RD, ST_SC_LD, ST_SC_DIF, ST_SC_MUL, ST_SC_SUM, ST_SC_DEC,
        ST_NEXT,
        ST_CL_RD, ST_CL_LD, ST_CL_WR,
        ST_E_RD0, ST_E_LD0, ST_E_RD1, ST_E_LD1, ST_E_DIF, ST_E_MUL, ST_E_SUM, ST_E_CHK,
        ST_J_RD, ST_J_LD, ST_J_DIF, ST_J_MUL, ST_J_SUM, ST_J_UPD,
        ST_WMUL, ST_DIV, ST_BEST,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic              mem_we;
        t_wsel             mem_wsel;
        logic [AW-1:0]     mem_waddr;
        logic [AW-1:0]     mem_raddr;
        logic              o_ld_rd;
        logic              o_ld_c;
        logic              c_ld_rd;
        logic              c_ld_k;
        logic              k_ld_rd;
        logic              a_ld;
        logic              b_ld;
        logic              ext_clr;
        logic              ext_upd;
        logic              qlen_ld;
        logic              wm_clr;
        logic              wm_en;
        logic [1:0]        wm_sel;
        logic              wm_acc;
        logic              div_init;
        logic              div_step;
        logic              best_clr;
        logic              best_upd;
        logic              out_ld;
        logic [HULL_W-1:0] hull_cnt;
    } t_dp_cmd;

    typedef struct packed {
        logic lower;
        logic take;
        logic len_zero;
        logic out_busy;
    } t_dp_sts;

endpackage

`default_nettype wire

FILE: hdl/min_area_bounding_rectangle.sv
// Top level of the minimum-area bounding rectangle block.
// Depends on mabr_pkg, mabr_ctrl and mabr_dp (which holds the mabr_ram point store).
//
// Usage:
//   Input channel (i_in_valid / o_in_stall / i_in_data): one 2D point per item, signed
//   fixed point with 8 fraction bits. An item with last_point set closes the set.
//   Up to MAX_POINTS points are stored; further points are dropped, but a dropped
//   point with last_point set still closes the set.
//   Output channel (o_out_valid / i_out_stall / o_out_data): one item per set, the
//   smallest rectangle area (8 fraction bits, saturating) and the hull vertex count.
//   Sets of two or fewer points give area zero and count zero.
// Timing:
//   Loading accepts one point per cycle. After the closing item, o_in_stall stays high
//   while the set is processed: the start search, then per hull vertex the
//   gift-wrapping scan, then per hull edge the extent scan over the hull vertices,
//   the wide multiply and the bit-serial division. The scans are set by the one
//   read port of the point store and the serial take/extent evaluation.
// Reset and stall:
//   Synchronous active-low reset empties the set and drops any pending result.
//   The result waits in an output register while i_out_stall is high; input stays
//   stalled until that register is free and the result has been handed over.
`default_nettype none

module min_area_bounding_rectangle
    import mabr_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     i_in_valid,
    input  wire t_in_item i_in_data,
    output logic          o_in_stall,
    output logic          o_out_valid,
    output t_out_item     o_out_data,
    input  wire logic     i_out_stall
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    // sequence the load, hull walk and per-edge measurement
    mabr_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_in_last  (i_in_data.last_point),
        .o_in_stall (o_in_stall),
        .o_cmd      (cmd),
        .i_sts      (sts)
    );

    // hold points, evaluate products and areas, hold the result item
    mabr_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall)
    );

endmodule

`default_nettype wire

FILE: hdl/mabr_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mabr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

FILE: hdl/mabr_dp.sv
// Datapath: point store, point registers, product/sum stages, extent tracking,
// wide multiply, bit-serial divider, best area and result register.
// Depends on mabr_pkg and mabr_ram.
`default_nettype none

module mabr_dp
    import mabr_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_dp_cmd   i_cmd,
    output t_dp_sts        o_sts,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    output t_out_item      o_out_data,
    input  wire logic      i_out_stall
);

    function automatic logic [PW-1:0] smul(input logic [DW-1:0] a, input logic [DW-1:0] b);
        logic [PW-1:0] ae;
        logic [PW-1:0] be;
        ae   = {{DW{a[DW-1]}}, a};
        be   = {{DW{b[DW-1]}}, b};
        smul = ae * be;
    endfunction

    function automatic logic [SW-1:0] sx(input logic [PW-1:0] p);
        sx = {p[PW-1], p};
    endfunction

    function automatic logic pos(input logic [DW-1:0] v);
        pos = !v[DW-1] && (|v);
    endfunction

    // store
    logic [2*CW-1:0]      mem_wdata;
    logic [2*CW-1:0]      mem_rdata;
    logic signed [CW-1:0] rd_x;
    logic signed [CW-1:0] rd_y;

    // point registers
    logic signed [CW-1:0] r_ox, r_oy, r_cx, r_cy, r_kx, r_ky;
    logic signed [DW-1:0] r_ax, r_ay, r_bx, r_by;

    // product and sum stages
    logic [PW-1:0] r_p_axby, r_p_aybx, r_p_axax, r_p_ayay;
    logic [PW-1:0] r_p_bxbx, r_p_byby, r_p_axbx, r_p_ayby;
    logic signed [SW-1:0] r_t, r_la, r_lb, r_d;
    logic [SW-1:0] t_abs;

    // extents
    logic signed [SW-1:0] r_lo, r_hi;
    logic [SW-1:0]        r_h, r_span, r_qlen;
    logic [SW:0]          span_full;

    // wide multiply and divider
    logic [2*HW-1:0] span_e, h_e;
    logic [HW-1:0]   op_a, op_b;
    logic [2*HW-1:0] r_wp;
    logic [1:0]      r_wsel;
    logic [NW-1:0]   r_acc, wp_shift;
    logic [RW-1:0]   r_rem, rem_sh, dv;
    logic            div_ge;
    logic [AREA_W-1:0] r_quo;
    logic            r_sat;
    logic [AREA_W-1:0] area;

    // best and result
    logic [AREA_W-1:0] r_best;
    logic              r_best_v;
    logic              r_out_valid;
    t_out_item         r_out;

    logic opp, b_zero, k_eq_c;

    always_comb begin
        unique case (i_cmd.mem_wsel)
            WS_IN:   mem_wdata = {i_in_data.point_x, i_in_data.point_y};
            WS_K:    mem_wdata = {r_kx, r_ky};
            WS_C:    mem_wdata = {r_cx, r_cy};
            default: mem_wdata = {r_cx, r_cy};
        endcase
    end

    mabr_ram #(
        .WIDTH (2 * CW),
        .DEPTH (MAX_POINTS + 1)
    ) u_store (
        .i_clk   (i_clk),
        .i_we    (i_cmd.mem_we),
        .i_waddr (i_cmd.mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (i_cmd.mem_raddr),
        .o_rdata (mem_rdata)
    );

    assign rd_x = mem_rdata[2*CW-1:CW];
    assign rd_y = mem_rdata[CW-1:0];

    always_ff @(posedge i_clk) begin
        if (i_cmd.o_ld_rd) begin
            r_ox <= rd_x;
            r_oy <= rd_y;
        end else if (i_cmd.o_ld_c) begin
            r_ox <= r_cx;
            r_oy <= r_cy;
        end
        if (i_cmd.c_ld_rd) begin
            r_cx <= rd_x;
            r_cy <= rd_y;
        end else if (i_cmd.c_ld_k) begin
            r_cx <= r_kx;
            r_cy <= r_ky;
        end
        if (i_cmd.k_ld_rd) begin
            r_kx <= rd_x;
            r_ky <= rd_y;
        end
        if (i_cmd.a_ld) begin
            r_ax <= {r_cx[CW-1], r_cx} - {r_ox[CW-1], r_ox};
            r_ay <= {r_cy[CW-1], r_cy} - {r_oy[CW-1], r_oy};
        end
        if (i_cmd.b_ld) begin
            r_bx <= {r_kx[CW-1], r_kx} - {r_ox[CW-1], r_ox};
            r_by <= {r_ky[CW-1], r_ky} - {r_oy[CW-1], r_oy};
        end
    end

    // products, then sums: one register level each
    always_ff @(posedge i_clk) begin
        r_p_axby <= smul(r_ax, r_by);
        r_p_aybx <= smul(r_ay, r_bx);
        r_p_axax <= smul(r_ax, r_ax);
        r_p_ayay <= smul(r_ay, r_ay);
        r_p_bxbx <= smul(r_bx, r_bx);
        r_p_byby <= smul(r_by, r_by);
        r_p_axbx <= smul(r_ax, r_bx);
        r_p_ayby <= smul(r_ay, r_by);
        r_t      <= sx(r_p_axby) - sx(r_p_aybx);
        r_la     <= sx(r_p_axax) + sx(r_p_ayay);
        r_lb     <= sx(r_p_bxbx) + sx(r_p_byby);
        r_d      <= sx(r_p_axbx) + sx(r_p_ayby);
    end

    // candidate replacement test for gift wrapping
    assign opp    = (pos(r_ax) && r_bx[DW-1]) || (r_ax[DW-1] && pos(r_bx))
                 || (pos(r_ay) && r_by[DW-1]) || (r_ay[DW-1] && pos(r_by));
    assign b_zero = (r_bx == '0) && (r_by == '0);
    assign k_eq_c = (r_kx == r_cx) && (r_ky == r_cy);

    always_comb begin
        o_sts.take = r_t[SW-1]
                  || ((r_t == '0) && !(r_la < r_lb) && !opp && !b_zero && !k_eq_c);
        o_sts.lower    = (rd_y < r_cy) || ((rd_y == r_cy) && (rd_x < r_cx));
        o_sts.len_zero = (r_la == '0);
        o_sts.out_busy = r_out_valid;
    end

    assign t_abs     = r_t[SW-1] ? (~r_t + SW'(1)) : r_t;
    assign span_full = {r_hi[SW-1], r_hi} - {r_lo[SW-1], r_lo};

    always_ff @(posedge i_clk) begin
        r_span <= span_full[SW-1:0];
        if (i_cmd.ext_clr) begin
            r_lo <= '0;
            r_hi <= '0;
            r_h  <= '0;
        end else if (i_cmd.ext_upd) begin
            if (r_d < r_lo) r_lo <= r_d;
            if (r_d > r_hi) r_hi <= r_d;
            if (t_abs > r_h) r_h <= t_abs;
        end
        if (i_cmd.qlen_ld) begin
            r_qlen <= r_la;
        end
    end

    // wide product span * h from four partial products
    assign span_e = {{(2*HW-SW){1'b0}}, r_span};
    assign h_e    = {{(2*HW-SW){1'b0}}, r_h};
    assign op_a   = i_cmd.wm_sel[1] ? span_e[2*HW-1:HW] : span_e[HW-1:0];
    assign op_b   = i_cmd.wm_sel[0] ? h_e[2*HW-1:HW] : h_e[HW-1:0];

    always_comb begin
        case (r_wsel)
            2'd0:    wp_shift = {{(NW-2*HW){1'b0}}, r_wp};
            2'd3:    wp_shift = {r_wp, {(2*HW){1'b0}}};
            default: wp_shift = {{(NW-3*HW){1'b0}}, r_wp, {HW{1'b0}}};
        endcase
    end

    // restoring division, one quotient bit per cycle
    assign rem_sh = {r_rem[RW-2:0], r_acc[NW-1]};
    assign dv     = {{(RW-SW-8){1'b0}}, r_qlen, 8'd0};
    assign div_ge = (rem_sh >= dv);
    assign area   = r_sat ? AREA_MAX : r_quo;

    always_ff @(posedge i_clk) begin
        if (i_cmd.wm_en) begin
            r_wp   <= {{HW{1'b0}}, op_a} * {{HW{1'b0}}, op_b};
            r_wsel <= i_cmd.wm_sel;
        end
        if (i_cmd.wm_clr) begin
            r_acc <= '0;
        end else if (i_cmd.wm_acc) begin
            r_acc <= r_acc + wp_shift;
        end else if (i_cmd.div_step) begin
            r_acc <= {r_acc[NW-2:0], 1'b0};
        end
        if (i_cmd.div_init) begin
            r_rem <= '0;
            r_quo <= '0;
            r_sat <= 1'b0;
        end else if (i_cmd.div_step) begin
            r_rem <= div_ge ? (rem_sh - dv) : rem_sh;
            r_quo <= {r_quo[AREA_W-2:0], div_ge};
            r_sat <= r_sat | r_quo[AREA_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best_v    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.best_clr) begin
                r_best_v <= 1'b0;
            end else if (i_cmd.best_upd && (!r_best_v || (area < r_best))) begin
                r_best_v <= 1'b1;
            end
            if (i_cmd.out_ld) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.best_upd && (!r_best_v || (area < r_best))) begin
            r_best <= area;
        end
        if (i_cmd.out_ld) begin
            r_out.min_area   <= r_best_v ? r_best : '0;
            r_out.hull_count <= i_cmd.hull_cnt;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

`default_nettype wire

FILE: hdl/mabr_ctrl.sv
// Controller state machine: load, start search, gift-wrapping hull walk, per-edge
// rectangle measurement, wide multiply and division sequencing, result hand-off.
// Depends on mabr_pkg.
`default_nettype none

module mabr_ctrl
    import mabr_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_in_valid,
    input  wire logic    i_in_last,
    output logic         o_in_stall,
    output t_dp_cmd      o_cmd,
    input  wire t_dp_sts i_sts
);

    t_state r_state, n_state;
    logic [IW-1:0]     r_cnt, n_cnt, r_n, n_n, r_i, n_i, r_j, n_j;
    logic [IW-1:0]     r_m, n_m, r_cand, n_cand, r_start, n_start, r_hull, n_hull;
    logic [STEP_W-1:0] r_step, n_step;
    logic [IW-1:0]     i1, j1, m1, m2, cnt_new;
    logic              room;

    assign i1      = r_i + IW'(1);
    assign j1      = r_j + IW'(1);
    assign m1      = r_m + IW'(1);
    assign m2      = r_m + IW'(2);
    assign room    = (r_cnt < MAX_IDX);
    assign cnt_new = room ? (r_cnt + IW'(1)) : r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_LOAD;
            r_cnt   <= '0;
            r_n     <= '0;
            r_i     <= '0;
            r_j     <= '0;
            r_m     <= '0;
            r_cand  <= '0;
            r_start <= '0;
            r_hull  <= '0;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_n     <= n_n;
            r_i     <= n_i;
            r_j     <= n_j;
            r_m     <= n_m;
            r_cand  <= n_cand;
            r_start <= n_start;
            r_hull  <= n_hull;
            r_step  <= n_step;
        end
    end

    // next state and counters
    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        n_n     = r_n;
        n_i     = r_i;
        n_j     = r_j;
        n_m     = r_m;
        n_cand  = r_cand;
        n_start = r_start;
        n_hull  = r_hull;
        n_step  = r_step;
        unique case (r_state)
            ST_LOAD: begin
                if (i_in_valid) begin
                    n_cnt = cnt_new;
                    if (i_in_last) begin
                        if (cnt_new <= IW'(2)) begin
                            n_hull  = '0;
                            n_state = ST_DONE;
                        end else begin
                            n_n     = cnt_new;
                            n_i     = '0;
                            n_state = ST_FIND_RD;
                        end
                    end
                end
            end
            ST_FIND_RD: n_state = ST_FIND_LD;
            ST_FIND_LD: begin
                if ((r_i == '0) || i_sts.lower) n_start = r_i;
                n_i     = i1;
                n_state = (i1 < r_n) ? ST_FIND_RD : ST_FIND_WR;
            end
            ST_FIND_WR: begin
                n_m     = '0;
                n_state = ST_SW_RD;
            end
            ST_SW_RD: n_state = ST_SW_LD;
            ST_SW_LD: n_state = ST_SW_W1;
            ST_SW_W1: n_state = ST_SW_W2;
            ST_SW_W2: n_state = ST_C_RD;
            ST_C_RD:  n_state = ST_C_LD;
            ST_C_LD: begin
                n_cand  = m1;
                n_i     = m2;
                n_state = (m2 <= r_n) ? ST_SC_RD : ST_NEXT;
            end
            ST_SC_RD:  n_state = ST_SC_LD;
            ST_SC_LD:  n_state = ST_SC_DIF;
            ST_SC_DIF: n_state = ST_SC_MUL;
            ST_SC_MUL: n_state = ST_SC_SUM;
            ST_SC_SUM: n_state = ST_SC_DEC;
            ST_SC_DEC: begin
                if (i_sts.take) n_cand = r_i;
                n_i     = i1;
                n_state = (i1 <= r_n) ? ST_SC_RD : ST_NEXT;
            end
            ST_NEXT: begin
                if (r_cand == r_n) begin
                    n_hull  = m1;
                    n_state = ST_CL_RD;
                end else begin
                    n_start = r_cand;
                    if (m1 < r_n) begin
                        n_m     = m1;
                        n_state = ST_SW_RD;
                    end else begin
                        n_hull  = r_n;
                        n_state = ST_CL_RD;
                    end
                end
            end
            ST_CL_RD: n_state = ST_CL_LD;
            ST_CL_LD: n_state = ST_CL_WR;
            ST_CL_WR: begin
                n_i     = '0;
                n_state = ST_E_RD0;
            end
            ST_E_RD0: n_state = ST_E_LD0;
            ST_E_LD0: n_state = ST_E_RD1;
            ST_E_RD1: n_state = ST_E_LD1;
            ST_E_LD1: n_state = ST_E_DIF;
            ST_E_DIF: n_state = ST_E_MUL;
            ST_E_MUL: n_state = ST_E_SUM;
            ST_E_SUM: n_state = ST_E_CHK;
            ST_E_CHK: begin
                if (i_sts.len_zero) begin
                    n_i     = i1;
                    n_state = (i1 < r_hull) ? ST_E_RD0 : ST_DONE;
                end else begin
                    n_j     = '0;
                    n_state = ST_J_RD;
                end
            end
            ST_J_RD:  n_state = ST_J_LD;
            ST_J_LD:  n_state = ST_J_DIF;
            ST_J_DIF: n_state = ST_J_MUL;
            ST_J_MUL: n_state = ST_J_SUM;
            ST_J_SUM: n_state = ST_J_UPD;
            ST_J_UPD: begin
                n_j = j1;
                if (j1 < r_hull) begin
                    n_state = ST_J_RD;
                end else begin
                    n_step  = '0;
                    n_state = ST_WMUL;
                end
            end
            ST_WMUL: begin
                if (r_step == STEP_W'(5)) begin
                    n_step  = '0;
                    n_state = ST_DIV;
                end else begin
                    n_step = r_step + STEP_W'(1);
                end
            end
            ST_DIV: begin
                n_step = r_step + STEP_W'(1);
                if (r_step == STEP_W'(NW - 1)) n_state = ST_BEST;
            end
            ST_BEST: begin
                n_i     = i1;
                n_state = (i1 < r_hull) ? ST_E_RD0 : ST_DONE;
            end
            ST_DONE: begin
                if (!i_sts.out_busy) begin
                    n_cnt   = '0;
                    n_state = ST_LOAD;
                end
            end
            default: n_state = ST_LOAD;
        endcase
    end

    // commands
    always_comb begin
        o_cmd          = '0;
        o_cmd.mem_wsel = WS_IN;
        o_cmd.hull_cnt = HULL_W'(r_hull);
        o_in_stall     = (r_state != ST_LOAD);
        unique case (r_state)
            ST_LOAD: begin
                o_cmd.mem_we    = i_in_valid && room;
                o_cmd.mem_waddr = r_cnt[AW-1:0];
                o_cmd.best_clr  = i_in_valid && i_in_last;
            end
            ST_FIND_RD: o_cmd.mem_raddr = r_i[AW-1:0];
            ST_FIND_LD: o_cmd.c_ld_rd = (r_i == '0) || i_sts.lower;
            ST_FIND_WR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.mem_wsel  = WS_C;
                o_cmd.mem_waddr = r_n[AW-1:0];
            end
            ST_SW_RD: o_cmd.mem_raddr = r_m[AW-1:0];
            ST_SW_LD: o_cmd.k_ld_rd = 1'b1;
            ST_SW_W1: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.mem_wsel  = WS_K;
                o_cmd.mem_waddr = r_start[AW-1:0];
            end
            ST_SW_W2: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.mem_wsel  = WS_C;
                o_cmd.mem_waddr = r_m[AW-1:0];
                o_cmd.o_ld_c    = 1'b1;
            end
            ST_C_RD:   o_cmd.mem_raddr = m1[AW-1:0];
            ST_C_LD:   o_cmd.c_ld_rd = 1'b1;
            ST_SC_RD:  o_cmd.mem_raddr = r_i[AW-1:0];
            ST_SC_LD:  o_cmd.k_ld_rd = 1'b1;
            ST_SC_DIF: begin
                o_cmd.a_ld = 1'b1;
                o_cmd.b_ld = 1'b1;
            end
            ST_SC_DEC: o_cmd.c_ld_k = i_sts.take;
            ST_CL_RD:  o_cmd.mem_raddr = '0;
            ST_CL_LD:  o_cmd.k_ld_rd = 1'b1;
            ST_CL_WR: begin
                o_cmd.mem_we    = 1'b1;
                o_cmd.mem_wsel  = WS_K;
                o_cmd.mem_waddr = r_hull[AW-1:0];
            end
            ST_E_RD0: o_cmd.mem_raddr = r_i[AW-1:0];
            ST_E_LD0: o_cmd.o_ld_rd = 1'b1;
            ST_E_RD1: o_cmd.mem_raddr = i1[AW-1:0];
            ST_E_LD1: o_cmd.c_ld_rd = 1'b1;
            ST_E_DIF: o_cmd.a_ld = 1'b1;
            ST_E_CHK: begin
                o_cmd.qlen_ld = !i_sts.len_zero;
                o_cmd.ext_clr = !i_sts.len_zero;
                o_cmd.wm_clr  = !i_sts.len_zero;
            end
            ST_J_RD:  o_cmd.mem_raddr = r_j[AW-1:0];
            ST_J_LD:  o_cmd.k_ld_rd = 1'b1;
            ST_J_DIF: o_cmd.b_ld = 1'b1;
            ST_J_UPD: o_cmd.ext_upd = 1'b1;
            ST_WMUL: begin
                // step 0 lets the span register settle; steps 1-4 issue partial
                // products, steps 2-5 add them in
                o_cmd.wm_en    = (r_step >= STEP_W'(1)) && (r_step <= STEP_W'(4));
                o_cmd.wm_sel   = 2'(r_step - STEP_W'(1));
                o_cmd.wm_acc   = (r_step >= STEP_W'(2));
                o_cmd.div_init = (r_step == STEP_W'(5));
            end
            ST_DIV:  o_cmd.div_step = 1'b1;
            ST_BEST: o_cmd.best_upd = 1'b1;
            ST_DONE: o_cmd.out_ld = !i_sts.out_busy;
            default: o_cmd.mem_we = 1'b0;
        endcase
    end

endmodule

`default_nettype wire
